@@ sv/quaternion_to_euler_angles_defines.svh @@
// ----------------------------------------------------------------------------
// quaternion to euler angles assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every edge
`define QTE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("qte check failed");
// antecedent implies consequent in the following cycle
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qte check failed");
`else
`define QTE_ASSERT(lbl, cond)
`define QTE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// shared constants and types of the quaternion to euler angles pipeline
// ----------------------------------------------------------------------------
package qte_pkg;

  // integer square root: one result bit per stage
  localparam int SQ_N = 29;

  // atan2: fold, three normalize stages, cordic iterations, rounding
  localparam int CORDIC_N = 20;
  localparam int NORM_N   = 3;
  localparam int ATAN_LAT = 1 + NORM_N + CORDIC_N + 1;

  // angle accumulator counts 1/256 centidegree
  localparam logic signed [24:0] HALF_TURN_ACC = 25'sd4608000;

  localparam int ATAN_TAB [CORDIC_N] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3
  };

  // operands riding alongside the square root
  typedef struct packed {
    logic signed [33:0] yaw_n;
    logic signed [33:0] yaw_d;
    logic signed [33:0] roll_n;
    logic signed [33:0] roll_d;
    logic signed [29:0] s;
    logic               clip;
  } qte_side_t;

endpackage

@@ sv/qte_sqrt.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt
// pipelined restoring integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module qte_sqrt import qte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [56:0] in_v,
  output logic        out_valid,
  output logic [28:0] out_root
);

  logic [56:0]     rem_r  [SQ_N];
  logic [28:0]     root_r [SQ_N];
  logic [SQ_N-1:0] vld_r;

  for (genvar j = 0; j < SQ_N; j++) begin : g_st
    localparam int K = SQ_N - 1 - j;
    logic [56:0] rin;
    logic [28:0] qin;
    logic        vin;
    logic [58:0] trial;

    if (j == 0) begin : g_first
      assign rin = in_v;
      assign qin = '0;
      assign vin = in_valid;
    end else begin : g_next
      assign rin = rem_r[j-1];
      assign qin = root_r[j-1];
      assign vin = vld_r[j-1];
    end

    // (root + 2^k)^2 - root^2
    assign trial = ({30'd0, qin} << (K + 1)) + (59'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, rin} >= trial) begin
          rem_r[j]  <= rin - trial[56:0];
          root_r[j] <= qin | (29'd1 << K);
        end else begin
          rem_r[j]  <= rin;
          root_r[j] <= qin;
        end
      end
    end
  end

  assign out_valid = vld_r[SQ_N-1];
  assign out_root  = root_r[SQ_N-1];

endmodule

@@ sv/qte_atan2.sv @@
// ----------------------------------------------------------------------------
// qte_atan2
// pipelined vectoring cordic atan2, result in centidegrees
// ----------------------------------------------------------------------------
module qte_atan2 import qte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [33:0] in_y,
  input  logic signed [33:0] in_x,
  output logic               out_valid,
  output logic signed [15:0] out_angle
);

  typedef struct packed {
    logic               zero;
    logic signed [42:0] x;
    logic signed [42:0] y;
    logic [40:0]        orv;
    logic signed [24:0] z;
  } at_norm_t;

  typedef struct packed {
    logic               zero;
    logic signed [44:0] x;
    logic signed [44:0] y;
    logic signed [24:0] z;
  } at_cor_t;

  // fold into the right half plane
  logic signed [34:0] xe, ye;
  logic [34:0]        ax, ay;
  at_norm_t           f_r;
  logic               f_vld_r;

  assign xe = 35'(in_x);
  assign ye = 35'(in_y);
  assign ax = (xe < 0) ? 35'(-xe) : 35'(xe);
  assign ay = (ye < 0) ? 35'(-ye) : 35'(ye);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r.zero <= (in_x == '0) && (in_y == '0);
      f_r.orv  <= 41'(ax | ay);
      if (xe < 0) begin
        f_r.x <= 43'(-xe);
        f_r.y <= 43'(-ye);
        f_r.z <= (ye >= 0) ? HALF_TURN_ACC : -HALF_TURN_ACC;
      end else begin
        f_r.x <= 43'(xe);
        f_r.y <= 43'(ye);
        f_r.z <= '0;
      end
    end
  end

  // normalize: larger magnitude into [2^40, 2^41), two shift steps per stage
  at_norm_t          n_r [NORM_N];
  logic [NORM_N-1:0] n_vld_r;

  for (genvar j = 0; j < NORM_N; j++) begin : g_norm
    localparam int SH1 = 1 << (5 - 2 * j);
    localparam int SH2 = 1 << (4 - 2 * j);
    at_norm_t nin, mid, nout;
    logic     vin;

    if (j == 0) begin : g_first
      assign nin = f_r;
      assign vin = f_vld_r;
    end else begin : g_next
      assign nin = n_r[j-1];
      assign vin = n_vld_r[j-1];
    end

    always_comb begin
      mid = nin;
      if ((nin.orv >> (41 - SH1)) == '0) begin
        mid.x   = nin.x <<< SH1;
        mid.y   = nin.y <<< SH1;
        mid.orv = nin.orv << SH1;
      end
      nout = mid;
      if ((mid.orv >> (41 - SH2)) == '0) begin
        nout.x   = mid.x <<< SH2;
        nout.y   = mid.y <<< SH2;
        nout.orv = mid.orv << SH2;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        n_vld_r[j] <= 1'b0;
      end else if (en) begin
        n_vld_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j] <= nout;
      end
    end
  end

  // cordic rotations, one per stage
  at_cor_t             c_r [CORDIC_N];
  logic [CORDIC_N-1:0] c_vld_r;

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cor
    at_cor_t cin, cout;
    logic    vin;

    if (i == 0) begin : g_first
      assign cin.zero = n_r[NORM_N-1].zero;
      assign cin.x    = 45'(n_r[NORM_N-1].x);
      assign cin.y    = 45'(n_r[NORM_N-1].y);
      assign cin.z    = n_r[NORM_N-1].z;
      assign vin      = n_vld_r[NORM_N-1];
    end else begin : g_next
      assign cin = c_r[i-1];
      assign vin = c_vld_r[i-1];
    end

    always_comb begin
      cout.zero = cin.zero;
      if (cin.y > 0) begin
        cout.x = cin.x + (cin.y >>> i);
        cout.y = cin.y - (cin.x >>> i);
        cout.z = cin.z + 25'(ATAN_TAB[i]);
      end else begin
        cout.x = cin.x - (cin.y >>> i);
        cout.y = cin.y + (cin.x >>> i);
        cout.z = cin.z - 25'(ATAN_TAB[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_vld_r[i] <= 1'b0;
      end else if (en) begin
        c_vld_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[i] <= cout;
      end
    end
  end

  // round to centidegrees and clamp to a half turn
  logic signed [24:0] zr;
  logic signed [15:0] ang;
  logic signed [15:0] out_angle_r;
  logic               out_valid_r;

  assign zr = (c_r[CORDIC_N-1].z + 25'sd128) >>> 8;

  always_comb begin
    priority if (c_r[CORDIC_N-1].zero) begin
      ang = '0;
    end else if (zr > 25'sd18000) begin
      ang = 16'sd18000;
    end else if (zr < -25'sd18000) begin
      ang = -16'sd18000;
    end else begin
      ang = 16'(zr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_vld_r[CORDIC_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle_r <= ang;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule

@@ sv/quaternion_to_euler_angles.sv @@
// pipeline: 4 arithmetic stages, 29 square root stages, 25 atan2 stages and
//   1 output register from input transaction to result
// throughput: one transaction per cycle; the whole pipeline holds while a
//   result waits at the output, set by the single output register
// reset: rst_n synchronous active low, clears valid bits and declination
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// zyx quaternion to yaw, pitch and roll in centidegrees, fully pipelined
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic signed [15:0] cfg_declination_centideg,
  // input transaction
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_q_w,
  input  logic signed [15:0] in_q_x,
  input  logic signed [15:0] in_q_y,
  input  logic signed [15:0] in_q_z,
  // result transaction
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_yaw_centideg,
  output logic signed [14:0] out_pitch_centideg,
  output logic signed [15:0] out_roll_centideg,
  output logic               out_pitch_clipped
);

  // pipeline advances whenever the output register is free or being drained
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // declination register
  logic signed [15:0] decl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= '0;
    end else if (cfg_wr_en) begin
      decl_r <= cfg_declination_centideg;
    end
  end

  // stage 1: the ten component products, exact q28
  logic signed [31:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r;
  logic signed [31:0] p_xy_r, p_wz_r, p_wx_r, p_yz_r, p_xz_r, p_wy_r;
  logic               v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ww_r <= 32'(in_q_w) * 32'(in_q_w);
      p_xx_r <= 32'(in_q_x) * 32'(in_q_x);
      p_yy_r <= 32'(in_q_y) * 32'(in_q_y);
      p_zz_r <= 32'(in_q_z) * 32'(in_q_z);
      p_xy_r <= 32'(in_q_x) * 32'(in_q_y);
      p_wz_r <= 32'(in_q_w) * 32'(in_q_z);
      p_wx_r <= 32'(in_q_w) * 32'(in_q_x);
      p_yz_r <= 32'(in_q_y) * 32'(in_q_z);
      p_xz_r <= 32'(in_q_x) * 32'(in_q_z);
      p_wy_r <= 32'(in_q_w) * 32'(in_q_y);
    end
  end

  // stage 2: atan2 operands and saturated asin argument
  logic signed [33:0] s_raw;
  logic signed [29:0] s_sat;
  logic               s_clip;
  qte_side_t          side2_r;
  logic               v2_r;

  assign s_raw = (34'(p_xz_r) - 34'(p_wy_r)) <<< 1;

  always_comb begin
    priority if (s_raw > 34'sd268435456) begin
      s_sat  = 30'sd268435456;
      s_clip = 1'b1;
    end else if (s_raw < -34'sd268435456) begin
      s_sat  = -30'sd268435456;
      s_clip = 1'b1;
    end else begin
      s_sat  = 30'(s_raw);
      s_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r.yaw_n  <= (34'(p_xy_r) + 34'(p_wz_r)) <<< 1;
      side2_r.yaw_d  <= 34'(p_ww_r) + 34'(p_xx_r) - 34'(p_yy_r) - 34'(p_zz_r);
      side2_r.roll_n <= (34'(p_wx_r) + 34'(p_yz_r)) <<< 1;
      side2_r.roll_d <= 34'(p_ww_r) - 34'(p_xx_r) - 34'(p_yy_r) + 34'(p_zz_r);
      side2_r.s      <= s_sat;
      side2_r.clip   <= s_clip;
    end
  end

  // stage 3: s squared, |s| is at most 2^28
  logic [28:0] s_abs;
  logic [57:0] ss_full;
  logic [56:0] ss_r;
  qte_side_t   side3_r;
  logic        v3_r;

  assign s_abs   = (side2_r.s < 0) ? 29'(-side2_r.s) : 29'(side2_r.s);
  assign ss_full = 58'(s_abs) * 58'(s_abs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_r    <= ss_full[56:0];
      side3_r <= side2_r;
    end
  end

  // stage 4: radicand 1 - s^2 in q56
  logic [56:0] rad_r;
  qte_side_t   side4_r;
  logic        v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r   <= (57'd1 << 56) - ss_r;
      side4_r <= side3_r;
    end
  end

  // square root gives the asin cosine term; the other operands wait alongside
  logic        sq_valid;
  logic [28:0] sq_root;
  qte_side_t   sd_r [SQ_N];

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v4_r),
    .in_v      (rad_r),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= side4_r;
      for (int k = 1; k < SQ_N; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // three atan2 lanes in lockstep
  logic               yaw_vld, pitch_vld, roll_vld;
  logic signed [15:0] yaw_ang, pitch_ang, roll_ang;
  logic               clip_r [ATAN_LAT];

  qte_atan2 u_atan_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_valid),
    .in_y      (sd_r[SQ_N-1].yaw_n),
    .in_x      (sd_r[SQ_N-1].yaw_d),
    .out_valid (yaw_vld),
    .out_angle (yaw_ang)
  );

  qte_atan2 u_atan_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_valid),
    .in_y      (34'(sd_r[SQ_N-1].s)),
    .in_x      (34'({5'd0, sq_root})),
    .out_valid (pitch_vld),
    .out_angle (pitch_ang)
  );

  qte_atan2 u_atan_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_valid),
    .in_y      (sd_r[SQ_N-1].roll_n),
    .in_x      (sd_r[SQ_N-1].roll_d),
    .out_valid (roll_vld),
    .out_angle (roll_ang)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      clip_r[0] <= sd_r[SQ_N-1].clip;
      for (int k = 1; k < ATAN_LAT; k++) begin
        clip_r[k] <= clip_r[k-1];
      end
    end
  end

  // output register: declination, pitch sign and clamp
  logic signed [16:0] pitch_neg;
  logic signed [14:0] pitch_fin;
  logic signed [16:0] out_yaw_r;
  logic signed [14:0] out_pitch_r;
  logic signed [15:0] out_roll_r;
  logic               out_clip_r;

  assign pitch_neg = -17'(pitch_ang);

  always_comb begin
    priority if (pitch_neg > 17'sd9000) begin
      pitch_fin = 15'sd9000;
    end else if (pitch_neg < -17'sd9000) begin
      pitch_fin = -15'sd9000;
    end else begin
      pitch_fin = 15'(pitch_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= yaw_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_yaw_r   <= 17'(yaw_ang) - 17'(decl_r);
      out_pitch_r <= pitch_fin;
      out_roll_r  <= roll_ang;
      out_clip_r  <= clip_r[ATAN_LAT-1];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_yaw_centideg   = out_yaw_r;
  assign out_pitch_centideg = out_pitch_r;
  assign out_roll_centideg  = out_roll_r;
  assign out_pitch_clipped  = out_clip_r;

  // the three atan2 lanes stay aligned
  `QTE_ASSERT(a_lanes_aligned, (yaw_vld == pitch_vld) && (pitch_vld == roll_vld))
  // pitch stays within a quarter turn
  `QTE_ASSERT(a_pitch_range, !out_valid_r || ((out_pitch_r <= 15'sd9000) && (out_pitch_r >= -15'sd9000)))
  // a stall freezes the middle of the pipeline
  `QTE_ASSERT_NEXT(a_stall_freeze, !adv, $stable(v2_r) && $stable(sq_valid) && $stable(yaw_vld))

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion to euler angles testbench
// a directed table of quaternions and then random ones are sent; expected angles
// come from the typed row or a bit-exact integer cordic predictor, and each result
// transaction is compared with the oldest expected angle set
// ----------------------------------------------------------------------------
module tb;

  localparam int PIPE_LAT = 59;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 630;

  localparam longint HALF_TURN = 64'sd4608000;
  localparam longint ONE_Q28   = 64'sd1 << 28;

  typedef struct {
    logic signed [16:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic               clip;
  } angles_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic               known;   // expected angles typed into the row
    angles_t            ang;
  } quat_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic signed [15:0] cfg_declination_centideg = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_q_w = '0, in_q_x = '0, in_q_y = '0, in_q_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [16:0] out_yaw_centideg;
  logic signed [14:0] out_pitch_centideg;
  logic signed [15:0] out_roll_centideg;
  logic out_pitch_clipped;

  quaternion_to_euler_angles uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_declination_centideg(cfg_declination_centideg),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_q_w(in_q_w), .in_q_x(in_q_x), .in_q_y(in_q_y), .in_q_z(in_q_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_yaw_centideg(out_yaw_centideg), .out_pitch_centideg(out_pitch_centideg),
    .out_roll_centideg(out_roll_centideg), .out_pitch_clipped(out_pitch_clipped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: declination as the block holds it
  longint  decl_cd = 0;
  angles_t pending_angles[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 0;   // percent of cycles the sender holds back
  int      recv_stall_pct = 0;  // percent of cycles the receiver stalls
  bit      hold_off = 1'b0;     // long receiver hold-off in progress

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // vectoring cordic atan2 in centidegrees
  function automatic longint atan2_cd(longint y, longint x);
    longint ang_tab[20] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                            11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22,
                            11, 6, 3};
    longint acc, m, nx, ny, r;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      acc = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    m = (x > (y < 0 ? -y : y)) ? x : (y < 0 ? -y : y);
    while (m < (64'sd1 << 40)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < 20; i++) begin
      if (y > 0) begin
        nx = x + asr(y, i);
        ny = y - asr(x, i);
        acc = acc + ang_tab[i];
      end else begin
        nx = x - asr(y, i);
        ny = y + asr(x, i);
        acc = acc - ang_tab[i];
      end
      x = nx;
      y = ny;
    end
    r = asr(acc + 128, 8);
    if (r > 18000) r = 18000;
    if (r < -18000) r = -18000;
    return r;
  endfunction

  function automatic angles_t euler_from_quat(logic signed [15:0] qw, qx, qy, qz);
    longint w, x, y, z, s, c, pitch;
    angles_t a;
    w = qw; x = qx; y = qy; z = qz;
    a.yaw  = 17'(atan2_cd(2 * (x * y + w * z), w * w + x * x - y * y - z * z) - decl_cd);
    a.roll = 16'(atan2_cd(2 * (w * x + y * z), w * w - x * x - y * y + z * z));
    s = 2 * (x * z - w * y);
    a.clip = 1'b0;
    if (s > ONE_Q28) begin
      s = ONE_Q28;
      a.clip = 1'b1;
    end
    if (s < -ONE_Q28) begin
      s = -ONE_Q28;
      a.clip = 1'b1;
    end
    c = isqrt((64'sd1 << 56) - s * s);
    pitch = -atan2_cd(s, c);
    if (pitch > 9000) pitch = 9000;
    if (pitch < -9000) pitch = -9000;
    a.pitch = 15'(pitch);
    return a;
  endfunction

  function automatic quat_row_t mk(int w, int x, int y, int z, bit known = 0,
                                   int yaw = 0, int pitch = 0, int roll = 0,
                                   bit clip = 0);
    quat_row_t r;
    r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
    r.known = known;
    r.ang.yaw = 17'(yaw); r.ang.pitch = 15'(pitch); r.ang.roll = 16'(roll);
    r.ang.clip = clip;
    return r;
  endfunction

  // send one quaternion transaction, idling first at the current rate
  task automatic send_quat(quat_row_t r);
    angles_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_q_w <= r.w; in_q_x <= r.x; in_q_y <= r.y; in_q_z <= r.z;
    a = r.known ? r.ang : euler_from_quat(r.w, r.x, r.y, r.z);
    do @(posedge clk); while (!in_ready);
    pending_angles.push_back(a);
  endtask

  // random quaternion: mostly components within +-8192, some within +-16384, some raw bit patterns for noise
  function automatic quat_row_t rand_quat();
    int c[4];
    int k;
    k = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      if (k == 0) c[i] = $signed(16'($urandom));
      else if (k == 1) c[i] = $urandom_range(32768) - 16384;
      else c[i] = $urandom_range(16384) - 8192;
    end
    if (k == 2) c[$urandom_range(3)] = 0;
    return mk(c[0], c[1], c[2], c[3]);
  endfunction

  task automatic drain_then_settle();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic write_declination(int v);
    cfg_wr_en <= 1'b1;
    cfg_declination_centideg <= 16'(v);
    decl_cd = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: stalls at the current rate, or holds off entirely
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        e = pending_angles.pop_front();
        if (e.yaw !== out_yaw_centideg || e.pitch !== out_pitch_centideg ||
            e.roll !== out_roll_centideg || e.clip !== out_pitch_clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angles exp y=%0d p=%0d r=%0d c=%0d got y=%0d p=%0d r=%0d c=%0d",
                     e.yaw, e.pitch, e.roll, e.clip, out_yaw_centideg,
                     out_pitch_centideg, out_roll_centideg, out_pitch_clipped);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("quaternion_to_euler_angles: mismatch");
        $finish;
      end
    end
  end

  initial begin
    quat_row_t dir_rows[$];
    int decl_set[4] = '{2500, -18000, 18000, -731};
    // directed table; typed rows are axis cases readable off the formulas
    dir_rows.push_back(mk(16384, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, 0, 1, 0, 0, 0, 0));             // zero vectors
    dir_rows.push_back(mk(0, 16384, 0, 0, 1, 0, 0, 18000, 0));     // negative x axis
    dir_rows.push_back(mk(-16384, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, 16384, 1, 18000, 0, 0, 0));
    dir_rows.push_back(mk(16384, 16384, 16384, 16384));
    dir_rows.push_back(mk(16384, 0, 16384, 0));                    // s below -1, clipped
    dir_rows.push_back(mk(16384, 0, -16384, 0));                   // s above 1, clipped
    dir_rows.push_back(mk(11585, 0, 11585, 0));                    // pitch near +90
    dir_rows.push_back(mk(11585, 0, 0, 11585));
    dir_rows.push_back(mk(11585, 11585, 0, 0));
    dir_rows.push_back(mk(-16384, -16384, -16384, -16384));
    dir_rows.push_back(mk(32767, -32768, 32767, -32768));          // out-of-range patterns
    dir_rows.push_back(mk(-32768, 32767, -32768, 32767));
    dir_rows.push_back(mk(-1, -1, -1, -1));
    dir_rows.push_back(mk(1, 0, 0, -1));
    dir_rows.push_back(mk(8192, -8192, 8192, -8192));
    dir_rows.push_back(mk(0, 0, 16384, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_quat(dir_rows[i]);
    drain_then_settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_declination(decl_set[ph]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk);
            hold_off = 1'b0;
          end
          for (int i = 0; i < 90; i++) send_quat(rand_quat());
        join
      end
      for (int i = 0; i < N_RANDOM / 4 - (ph == 0 ? 90 : 0); i++) send_quat(rand_quat());
      drain_then_settle();
    end

    if (mismatches == 0) begin
      $display("quaternion_to_euler_angles: match");
    end else begin
      $display("quaternion_to_euler_angles: mismatch");
    end
    $finish;
  end

endmodule
